// ===== hdl/pfa_pkg.sv =====
// pfa_pkg: shared types and constants of the prime field ALU.
// Operation codes and the class record passed from front to back.
// No dependencies.
package pfa_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_INV = 3'd5;
	localparam logic [2:0] OP_RED = 3'd6;
	localparam logic [2:0] OP_POW = 3'd7;

	localparam int MOD_RESET = 32749;

	typedef struct packed {
		logic [2:0] op;
		logic       err;
		logic [6:0] cnt;
	} pfa_cls_t;

endpackage

// ===== hdl/pfa_front.sv =====
// pfa_front: modulus register, request acceptance and classification.
// Flags bad modulus, unreduced operands and zero power count; saturates count.
// Depends on pfa_pkg.
module pfa_front import pfa_pkg::*; #(
	parameter int EB   = 15,
	parameter int MAXP = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [EB:0]         cfg_wdata,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [2:0]          operation,
	input  logic signed [31:0]  operand_a,
	input  logic [EB-1:0]       operand_b,
	input  logic [6:0]          power_count,
	output logic [EB:0]         p,
	input  logic                q_full,
	output logic                q_wr,
	output pfa_cls_t            cls
);

	logic [EB:0] mod_q;
	logic        mod_bad, a_bad, b_bad, uses_a, uses_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= (EB+1)'(MOD_RESET);
		end else if (cfg_we) begin
			mod_q <= cfg_wdata;
		end
	end

	assign p = mod_q;
	assign req_ready = ~q_full;
	assign q_wr = req_valid & ~q_full;

	always_comb begin
		mod_bad = (mod_q < (EB+1)'(2)) | (mod_q[EB] & (|mod_q[EB-1:0]));
		a_bad   = operand_a[31] | ({1'b0, operand_a[30:0]} >= 32'(mod_q));
		b_bad   = {1'b0, operand_b} >= mod_q;
		uses_a  = (operation != OP_RED) && (operation != OP_POW);
		uses_b  = (operation == OP_ADD) || (operation == OP_SUB) ||
			(operation == OP_MUL) || (operation == OP_DIV);
		cls.op  = operation;
		cls.err = mod_bad | (uses_a & a_bad) | (uses_a & uses_b & b_bad) |
			((operation == OP_POW) & (power_count == 7'd0));
		cls.cnt = (power_count > 7'(MAXP)) ? 7'(MAXP) : power_count;
	end

endmodule

// ===== hdl/pfa_queue.sv =====
// pfa_queue: two-entry queue between front and back.
// Plain storage, no dependencies.
module pfa_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wr_data,
	output logic         full,
	output logic         rd_valid,
	input  logic         rd,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	assign full     = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem[rd_ptr_q];

endmodule

// ===== hdl/pfa_div.sv =====
// pfa_div: restoring divider, one quotient bit per cycle.
// Gives quotient and remainder; no dependencies.
module pfa_div #(
	parameter int DW = 32,
	parameter int PW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [PW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [PW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] acc_q;
	logic [PW-1:0] rem_q, dvs_q;
	logic [PW:0]   shifted, nrem;
	logic          ge;

	always_comb begin
		shifted = {rem_q, acc_q[DW-1]};
		ge      = shifted >= {1'b0, dvs_q};
		nrem    = ge ? shifted - {1'b0, dvs_q} : shifted;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DW-2:0], ge};
			rem_q <= nrem[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = acc_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/pfa_back.sv =====
// pfa_back: sequencer that carries out one classified request at a time.
// Uses the shared divider for each reduce and multiply and each Euclid step.
// Depends on pfa_pkg.
module pfa_back import pfa_pkg::*; #(
	parameter int EB = 15,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [EB:0]   p,
	input  logic          q_valid,
	output logic          q_rd,
	input  pfa_cls_t      cls,
	input  logic [31:0]   qa,
	input  logic [EB-1:0] qb,
	output logic          d_start,
	output logic [DW-1:0] d_dvd,
	output logic [EB:0]   d_dvs,
	input  logic          d_done,
	input  logic [DW-1:0] d_quo,
	input  logic [EB:0]   d_rem,
	output logic          res_valid,
	input  logic          res_ready,
	output logic [EB-1:0] value,
	output logic          error,
	output logic          last
);

	localparam int PW = EB + 1;
	localparam int TW = EB + 2;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED  = 4'd1;
	localparam logic [3:0] S_PMUL = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_MDIV = 4'd4;
	localparam logic [3:0] S_ETST = 4'd5;
	localparam logic [3:0] S_EDIV = 4'd6;
	localparam logic [3:0] S_EMUL = 4'd7;
	localparam logic [3:0] S_ETUP = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]           state_q;
	logic [2:0]           op_q;
	logic [31:0]          a_q;
	logic [6:0]           cnt_q;
	logic [EB-1:0]        val_q, red_q, ma_q, mb_q;
	logic                 err_q, last_q, dstart_q;
	logic [DW-1:0]        dvd_q;
	logic [PW-1:0]        dvs_q, r0_q, r1_q, q_q;
	logic signed [TW-1:0] t0_q, t1_q;
	logic [2*EB-1:0]      prod_q;
	logic signed [PW+TW:0] qt_q;

	logic [PW-1:0] sum, dif, neg, redv;
	logic [TW-1:0] invv;
	logic [31:0]   absa;

	always_comb begin
		sum  = {1'b0, qa[EB-1:0]} + {1'b0, qb};
		if (sum >= p) begin
			sum = sum - p;
		end
		dif  = (qa[EB-1:0] >= qb) ? {1'b0, qa[EB-1:0]} - {1'b0, qb}
			: {1'b0, qa[EB-1:0]} + p - {1'b0, qb};
		neg  = (qa[EB-1:0] == '0) ? '0 : p - {1'b0, qa[EB-1:0]};
		absa = qa[31] ? 32'(-qa) : qa;
		redv = (a_q[31] && d_rem != '0) ? p - d_rem : d_rem;
		invv = t0_q[TW-1] ? t0_q + {1'b0, p} : t0_q;
	end

	assign q_rd      = (state_q == S_IDLE) & q_valid;
	assign d_start   = dstart_q;
	assign d_dvd     = dvd_q;
	assign d_dvs     = dvs_q;
	assign res_valid = state_q == S_OUT;
	assign value     = val_q;
	assign error     = err_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= cls.op;
				a_q   <= qa;
				cnt_q <= cls.cnt;
				err_q <= cls.err;
				last_q <= 1'b1;
				val_q <= '0;
				ma_q  <= qa[EB-1:0];
				mb_q  <= qb;
				dvd_q <= DW'(absa);
				dvs_q <= p;
				r0_q  <= p;
				r1_q  <= (cls.op == OP_DIV) ? {1'b0, qb} : qa[PW-1:0];
				t0_q  <= '0;
				t1_q  <= TW'(1);
				if (!cls.err) begin
					if (cls.op == OP_ADD) begin
						val_q <= sum[EB-1:0];
					end else if (cls.op == OP_SUB) begin
						val_q <= dif[EB-1:0];
					end else if (cls.op == OP_NEG) begin
						val_q <= neg[EB-1:0];
					end
				end
			end
			S_RED: begin
				if (d_done) begin
					red_q  <= redv[EB-1:0];
					val_q  <= (op_q == OP_POW) ? EB'(1) : redv[EB-1:0];
					last_q <= (op_q != OP_POW) || (cnt_q == 7'd1);
				end
			end
			S_PMUL: begin
				prod_q <= ma_q * mb_q;
			end
			S_MUL: begin
				dvd_q <= DW'(prod_q);
				dvs_q <= p;
			end
			S_MDIV: begin
				if (d_done) begin
					val_q  <= d_rem[EB-1:0];
					last_q <= (op_q != OP_POW) || (cnt_q == 7'd1);
				end
			end
			S_ETST: begin
				dvd_q <= DW'(r0_q);
				dvs_q <= r1_q;
				if (r1_q == '0) begin
					if (r0_q != PW'(1)) begin
						err_q <= 1'b1;
						val_q <= '0;
					end else begin
						val_q <= invv[EB-1:0];
						ma_q  <= a_q[EB-1:0];
						mb_q  <= invv[EB-1:0];
					end
				end
			end
			S_EDIV: begin
				if (d_done) begin
					q_q  <= d_quo[PW-1:0];
					r0_q <= r1_q;
					r1_q <= d_rem;
				end
			end
			S_EMUL: begin
				qt_q <= $signed({1'b0, q_q}) * t1_q;
			end
			S_ETUP: begin
				t0_q <= t1_q;
				t1_q <= t0_q - qt_q[TW-1:0];
			end
			S_OUT: begin
				if (res_ready) begin
					cnt_q <= cnt_q - 7'd1;
					ma_q  <= val_q;
					mb_q  <= red_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dstart_q <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (cls.err) begin
							state_q <= S_OUT;
						end else begin
							case (cls.op)
								OP_ADD, OP_SUB, OP_NEG: state_q <= S_OUT;
								OP_MUL: state_q <= S_PMUL;
								OP_DIV, OP_INV: state_q <= S_ETST;
								default: begin
									dstart_q <= 1'b1;
									state_q  <= S_RED;
								end
							endcase
						end
					end
				end
				S_RED: begin
					if (d_done) begin
						state_q <= S_OUT;
					end
				end
				S_PMUL: state_q <= S_MUL;
				S_MUL: begin
					dstart_q <= 1'b1;
					state_q  <= S_MDIV;
				end
				S_MDIV: begin
					if (d_done) begin
						state_q <= S_OUT;
					end
				end
				S_ETST: begin
					if (r1_q == '0) begin
						if (r0_q != PW'(1) || op_q == OP_INV) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_PMUL;
						end
					end else begin
						dstart_q <= 1'b1;
						state_q  <= S_EDIV;
					end
				end
				S_EDIV: begin
					if (d_done) begin
						state_q <= S_EMUL;
					end
				end
				S_EMUL: state_q <= S_ETUP;
				S_ETUP: state_q <= S_ETST;
				S_OUT: begin
					if (res_ready) begin
						if (op_q == OP_POW && !last_q && !err_q) begin
							state_q <= S_PMUL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/prime_field_alu_core.sv =====
// prime_field_alu_core: modular arithmetic unit over GF(p), p configurable.
// Front classifier, two-entry queue, sequencing back end and shared divider.
// Depends on pfa_pkg, pfa_front, pfa_queue, pfa_div, pfa_back.
//
//   port group  | handshake            | payload
//   ------------+----------------------+---------------------------------------
//   request     | req_valid/req_ready  | operation, operand_a, operand_b, power_count
//   result      | res_valid/res_ready  | value, error, last
//   config      | cfg_we               | cfg_wdata (modulus)
//
// Add, sub, neg and errors need no divider. Mul and reduce use the divider (DW = 32
// by default, one divider bit per cycle). Inverse: one divider pass per Euclid
// step, up to about 23 steps; divide adds one mul. Powers: one mul per result after the first.
// Reset restores p = 32749 and empties the queue. A stalled result holds the
// back end; the front keeps taking requests until the queue is full.
module prime_field_alu_core import pfa_pkg::*; #(
	parameter int ELEMENT_BITS = 15,
	parameter int MAX_POWERS   = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ELEMENT_BITS:0]     cfg_wdata,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [2:0]                operation,
	input  logic signed [31:0]        operand_a,
	input  logic [ELEMENT_BITS-1:0]   operand_b,
	input  logic [6:0]                power_count,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [ELEMENT_BITS-1:0]   value,
	output logic                      error,
	output logic                      last
);

	localparam int EB = ELEMENT_BITS;
	localparam int DW = (2 * EB > 32) ? 2 * EB : 32;
	localparam int QW = $bits(pfa_cls_t) + 32 + EB;

	logic [EB:0]   p;
	logic          q_full, q_wr, q_valid, q_rd;
	pfa_cls_t      cls_in, cls_out;
	logic [QW-1:0] q_wdata, q_rdata;
	logic [31:0]   qa;
	logic [EB-1:0] qb;
	logic          d_start, d_done;
	logic [DW-1:0] d_dvd, d_quo;
	logic [EB:0]   d_dvs, d_rem;

	pfa_front #(.EB(EB), .MAXP(MAX_POWERS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_ready(req_ready), .operation(operation),
		.operand_a(operand_a), .operand_b(operand_b), .power_count(power_count),
		.p(p), .q_full(q_full), .q_wr(q_wr), .cls(cls_in)
	);

	assign q_wdata = {cls_in, operand_a, operand_b};

	pfa_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr(q_wr), .wr_data(q_wdata), .full(q_full),
		.rd_valid(q_valid), .rd(q_rd), .rd_data(q_rdata)
	);

	assign {cls_out, qa, qb} = q_rdata;

	pfa_div #(.DW(DW), .PW(EB + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .dividend(d_dvd),
		.divisor(d_dvs), .done(d_done), .quo(d_quo), .rem(d_rem)
	);

	pfa_back #(.EB(EB), .DW(DW)) u_back (
		.clk(clk), .arst_n(arst_n), .p(p), .q_valid(q_valid), .q_rd(q_rd),
		.cls(cls_out), .qa(qa), .qb(qb), .d_start(d_start), .d_dvd(d_dvd),
		.d_dvs(d_dvs), .d_done(d_done), .d_quo(d_quo), .d_rem(d_rem),
		.res_valid(res_valid), .res_ready(res_ready), .value(value),
		.error(error), .last(last)
	);

endmodule
